// ----- sv/tvt_pkg.sv -----
// ----------------------------------------------------------------------------
// tvt_pkg
// Shared types and constants for the template variable tokenizer.
// ----------------------------------------------------------------------------
package tvt_pkg;

	localparam int MAX_LEN     = 4096;
	localparam int POS_W       = $clog2(MAX_LEN + 1);
	localparam int START_W     = $clog2(MAX_LEN);
	localparam int LEN_W       = POS_W;
	localparam int BYTE_W      = 8;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = ((START_W + LEN_W + 7) / 8) * 8;
	localparam int KIND_W      = 2;

	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [POS_W-1:0]   MAX_POS   = POS_W'(MAX_LEN);
	localparam logic [START_W-1:0] MAX_START = START_W'(MAX_LEN - 1);

	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_PIPE   = 8'h7C;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_DOUBLE = 2'd1,
		Q_SINGLE = 2'd2
	} quote_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NAME   = 2'd0,
		KIND_FILTER = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		PH_SEEK_NAME   = 5'b00001,
		PH_IN_NAME     = 5'b00010,
		PH_SEEK_PIPE   = 5'b00100,
		PH_SEEK_FILTER = 5'b01000,
		PH_IN_FILTER   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic              delim;
		logic              pipe;
		logic              colon;
		quote_t            quote;
		logic [POS_W-1:0]  pos;
		logic              last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ----- sv/tvt_front.sv -----
// ----------------------------------------------------------------------------
// tvt_front
// Accepts markup bytes, classifies them and tags each with its offset.
// ----------------------------------------------------------------------------
module tvt_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tvt_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] in_byte
	input  logic                            s_tlast,  // end_of_markup
	input  tvt_pkg::fifo_stat_t             stat,
	output logic                            push,
	output tvt_pkg::item_t                  item
);
	import tvt_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] ch;

	assign ch       = s_tdata[BYTE_W-1:0];
	assign s_tready = !stat.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		item.delim = (ch inside {CH_SPACE, CH_PIPE, CH_COMMA, [CH_TAB:CH_CR]});
		item.pipe  = (ch == CH_PIPE);
		item.colon = (ch == CH_COLON);
		case (ch)
			CH_DQUOTE: item.quote = Q_DOUBLE;
			CH_SQUOTE: item.quote = Q_SINGLE;
			default:   item.quote = Q_NONE;
		endcase
		item.pos  = pos_q;
		item.last = s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (s_tlast) begin
				pos_q <= '0;
			end else if (pos_q < MAX_POS) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

// ----- sv/tvt_fifo.sv -----
// ----------------------------------------------------------------------------
// tvt_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module tvt_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tvt_pkg::item_t       wr_item,
	input  logic                 pop,
	output tvt_pkg::item_t       rd_item,
	output tvt_pkg::fifo_stat_t  stat
);
	import tvt_pkg::*;

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop)
		else $error("queue read while empty");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + FIFO_CNT_W'(1))
		else $error("queue count slip");

endmodule

// ----- sv/tvt_back.sv -----
// ----------------------------------------------------------------------------
// tvt_back
// Fragment state machine; emits tokens into the output register.
// ----------------------------------------------------------------------------
module tvt_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tvt_pkg::fifo_stat_t              stat,
	input  tvt_pkg::item_t                   item,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tvt_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [11:0] token_start, [24:12] token_length
	output logic [tvt_pkg::KIND_W-1:0]       m_tuser,  // [1:0] token_kind
	output logic                             m_tlast   // markup_done
);
	import tvt_pkg::*;

	phase_t              phase_q, phase_d;
	quote_t              oqm_q, oqm_d;
	quote_t              obq_q, obq_d;
	logic                colon_q, colon_d;
	logic [START_W-1:0]  fstart_q, fstart_d;

	logic                m_tvalid_q;
	kind_t               out_kind_q;
	logic [START_W-1:0]  out_start_q;
	logic [LEN_W-1:0]    out_len_q;
	logic                out_last_q;

	logic                emit, emit_any;
	logic                e_filter, e_colon;
	logic [START_W-1:0]  e_start;
	logic [POS_W-1:0]    e_idx;
	logic [LEN_W-1:0]    span, len;
	kind_t               r_kind;
	logic [START_W-1:0]  r_start;
	logic [LEN_W-1:0]    r_len;

	assign pop = !stat.empty && (!m_tvalid_q || m_tready);

	always_comb begin
		phase_d  = phase_q;
		oqm_d    = oqm_q;
		obq_d    = obq_q;
		colon_d  = colon_q;
		fstart_d = fstart_q;
		emit     = 1'b0;
		e_filter = (phase_q == PH_IN_FILTER);
		e_colon  = 1'b0;
		e_start  = fstart_q;
		e_idx    = item.pos;

		case (phase_q)
			PH_IN_NAME, PH_IN_FILTER: begin
				if (obq_q != Q_NONE) begin
					if (item.quote == obq_q) begin
						emit    = 1'b1;
						phase_d = PH_SEEK_PIPE;
					end else begin
						colon_d = item.colon;
					end
				end else if (item.quote != Q_NONE) begin
					if (oqm_q == Q_NONE) begin
						oqm_d = item.quote;
					end else if (oqm_q == item.quote) begin
						oqm_d = Q_NONE;
					end
					colon_d = 1'b0;
				end else if (item.delim && oqm_q == Q_NONE) begin
					emit    = 1'b1;
					e_colon = colon_q;
					e_idx   = item.pos - POS_W'(1);
					phase_d = item.pipe ? PH_SEEK_FILTER : PH_SEEK_PIPE;
				end else begin
					colon_d = item.colon;
				end
			end
			PH_SEEK_PIPE: begin
				if (item.pipe) begin
					phase_d = PH_SEEK_FILTER;
				end
			end
			default: begin
				if (!item.delim) begin
					fstart_d = (item.pos < MAX_POS) ? item.pos[START_W-1:0] : MAX_START;
					obq_d    = item.quote;
					oqm_d    = item.quote;
					colon_d  = item.colon;
					phase_d  = (phase_q == PH_SEEK_FILTER) ? PH_IN_FILTER : PH_IN_NAME;
				end
			end
		endcase

		// end of markup closes an open fragment
		emit_any = emit;
		if (item.last && !emit) begin
			if (phase_d == PH_IN_NAME || phase_d == PH_IN_FILTER) begin
				emit_any = 1'b1;
				e_filter = (phase_d == PH_IN_FILTER);
				e_colon  = colon_d;
				e_start  = fstart_d;
				e_idx    = item.pos;
			end
		end

		span = e_idx - {1'b0, e_start} + LEN_W'(1);
		len  = (span > MAX_POS) ? MAX_POS : span;
		if (e_filter && e_colon && len != '0) begin
			len = len - LEN_W'(1);
		end

		if (emit_any) begin
			r_kind  = e_filter ? KIND_FILTER : KIND_NAME;
			r_start = e_start;
			r_len   = len;
		end else begin
			r_kind  = KIND_END;
			r_start = '0;
			r_len   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEEK_NAME;
			oqm_q    <= Q_NONE;
			obq_q    <= Q_NONE;
			colon_q  <= 1'b0;
			fstart_q <= '0;
		end else if (pop) begin
			if (item.last) begin
				phase_q  <= PH_SEEK_NAME;
				oqm_q    <= Q_NONE;
				obq_q    <= Q_NONE;
				colon_q  <= 1'b0;
				fstart_q <= '0;
			end else begin
				phase_q  <= phase_d;
				oqm_q    <= oqm_d;
				obq_q    <= obq_d;
				colon_q  <= colon_d;
				fstart_q <= fstart_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (!m_tvalid_q || m_tready) begin
			m_tvalid_q <= pop && (emit || item.last);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_kind_q  <= r_kind;
			out_start_q <= r_start;
			out_len_q   <= r_len;
			out_last_q  <= item.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_TDATA_W - START_W - LEN_W){1'b0}}, out_len_q, out_start_q};

	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_kind_q == KIND_END) |-> (out_last_q && out_start_q == '0 &&
		out_len_q == '0))
		else $error("end marker with token fields");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_len_q <= MAX_POS))
		else $error("token length beyond limit");

	a_reset_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.last) |=> (phase_q == PH_SEEK_NAME && oqm_q == Q_NONE &&
		obq_q == Q_NONE && !colon_q))
		else $error("state not cleared after end of markup");

endmodule

// ----- sv/template_variable_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// template_variable_tokenizer_top
// Byte-serial tokenizer for variable markup: reports name and filter names.
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata[7:0] byte, tlast end of markup
// m_*      out  tvalid/tready      tdata[11:0] start, [24:12] length,
//                                  tuser kind, tlast markup done
//
// One byte per cycle while the queue is not full; a token passes through the
// front queue, then the output register, after the byte that closes it.
// Four-entry queue between classifier and state machine; either side stalls
// on its own. Output register refills in the cycle it is drained.
// arst_n clears the queue, the offset counter and the state machine.
// ----------------------------------------------------------------------------
module template_variable_tokenizer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tvt_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] in_byte
	input  logic                             s_tlast,  // end_of_markup
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tvt_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [11:0] token_start, [24:12] token_length
	output logic [tvt_pkg::KIND_W-1:0]       m_tuser,  // [1:0] token_kind
	output logic                             m_tlast   // markup_done
);
	import tvt_pkg::*;

	fifo_stat_t stat;
	item_t      wr_item, rd_item;
	logic       push, pop;

	tvt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.push     (push),
		.item     (wr_item)
	);

	tvt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.stat    (stat)
	);

	tvt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.item     (rd_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- verif/template_variable_tokenizer_top_test.sv -----
// ----------------------------------------------------------------------------
// template_variable_tokenizer_top_test
// Streams markup strings byte by byte into the tokenizer and checks every
// reported fragment against a cycle-free model of the name/filter scanner.
// A short directed set is followed by random markup in four traffic phases.
// The random markup is mostly well-formed name/filter text, with some noise.
// Two long strings exercise offset and length saturation.
// ----------------------------------------------------------------------------
module template_variable_tokenizer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tvt_pkg::*;

	localparam int          CYCLE_LIMIT = 500000;
	localparam int          PHASE_BYTES = 312;
	localparam logic [7:0]  CH_LF       = 8'h0A;
	localparam logic [7:0]  CH_VT       = 8'h0B;
	localparam logic [7:0]  CH_FF       = 8'h0C;

	typedef struct {
		logic [7:0] ch;
		logic       eom;
	} markup_byte_t;

	typedef struct {
		kind_t              kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic               done;
	} token_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]      m_tuser;
	logic                   m_tlast;

	markup_byte_t markup_bytes[$];
	token_t       pending_tokens[$];
	logic [7:0]   draft[$];
	logic         byte_taken     = 1'b0;
	int unsigned  send_gap_pct   = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count    = 0;
	string        ident_set      = "abcdefghijklmnopqrstuvwxyz_.[]0123456789";

	// scanner state
	phase_t      tok_phase   = PH_SEEK_NAME;
	int unsigned pos_cnt     = 0;
	int unsigned frag_start  = 0;
	quote_t      quote_open  = Q_NONE;
	quote_t      opener      = Q_NONE;
	logic        colon_prev  = 1'b0;

	template_variable_tokenizer_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic quote_t quote_of(logic [7:0] c);
		if (c == CH_DQUOTE) return Q_DOUBLE;
		if (c == CH_SQUOTE) return Q_SINGLE;
		return Q_NONE;
	endfunction

	function automatic logic is_sep(logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_PIPE, CH_COMMA};
	endfunction

	function automatic token_t close_fragment(int unsigned last_idx, logic colon);
		token_t      t;
		int unsigned len;
		t.kind = (tok_phase == PH_IN_FILTER) ? KIND_FILTER : KIND_NAME;
		len = (last_idx >= frag_start) ? last_idx - frag_start + 1 : 1;
		if (len > MAX_LEN)
			len = MAX_LEN;
		if (t.kind == KIND_FILTER && colon && len > 0)
			len--;
		t.start  = frag_start[START_W-1:0];
		t.length = len[LEN_W-1:0];
		t.done   = 1'b0;
		return t;
	endfunction

	task automatic tokenize_byte(logic [7:0] c, logic eom);
		int unsigned p;
		logic        hit;
		quote_t      q;
		token_t      tok;
		p   = pos_cnt;
		hit = 1'b0;
		q   = quote_of(c);
		case (tok_phase)
			PH_IN_NAME, PH_IN_FILTER: begin
				if (opener != Q_NONE) begin
					if (q == opener) begin
						tok       = close_fragment(p, 1'b0);
						hit       = 1'b1;
						tok_phase = PH_SEEK_PIPE;
					end else begin
						colon_prev = (c == CH_COLON);
					end
				end else if (q != Q_NONE) begin
					if (quote_open == Q_NONE)
						quote_open = q;
					else if (quote_open == q)
						quote_open = Q_NONE;
					colon_prev = 1'b0;
				end else if (is_sep(c) && quote_open == Q_NONE) begin
					tok       = close_fragment(p - 1, colon_prev);
					hit       = 1'b1;
					tok_phase = (c == CH_PIPE) ? PH_SEEK_FILTER : PH_SEEK_PIPE;
				end else begin
					colon_prev = (c == CH_COLON);
				end
			end
			PH_SEEK_PIPE: begin
				if (c == CH_PIPE)
					tok_phase = PH_SEEK_FILTER;
			end
			default: begin
				if (!is_sep(c)) begin
					frag_start = (p < MAX_LEN) ? p : MAX_LEN - 1;
					opener     = q;
					quote_open = q;
					colon_prev = (c == CH_COLON);
					tok_phase  = (tok_phase == PH_SEEK_FILTER) ? PH_IN_FILTER : PH_IN_NAME;
				end
			end
		endcase
		if (eom) begin
			if (!hit) begin
				if (tok_phase == PH_IN_NAME || tok_phase == PH_IN_FILTER) begin
					tok = close_fragment(p, colon_prev);
				end else begin
					tok.kind   = KIND_END;
					tok.start  = '0;
					tok.length = '0;
				end
			end
			tok.done = 1'b1;
			pending_tokens.push_back(tok);
			tok_phase  = PH_SEEK_NAME;
			pos_cnt    = 0;
			frag_start = 0;
			quote_open = Q_NONE;
			opener     = Q_NONE;
			colon_prev = 1'b0;
		end else begin
			pos_cnt = (p < MAX_LEN) ? p + 1 : MAX_LEN;
			if (hit)
				pending_tokens.push_back(tok);
		end
	endtask

	// ---- stimulus building ----
	function automatic logic [7:0] ident_char();
		return ident_set[$urandom_range(ident_set.len() - 1)];
	endfunction

	function automatic logic [7:0] text_char();
		case ($urandom_range(7))
			0:       return CH_SPACE;
			1:       return CH_PIPE;
			2:       return CH_COMMA;
			3:       return $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
			4:       return 8'($urandom_range(128, 255));
			default: return ident_char();
		endcase
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(5))
			0:       return CH_PIPE;
			1:       return CH_COLON;
			2:       return $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
			3:       return CH_SPACE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic add_gap();
		logic [7:0] ws[6];
		ws = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
		repeat ($urandom_range(2))
			draft.push_back(ws[$urandom_range(5)]);
		if ($urandom_range(9) == 0)
			draft.push_back(CH_COMMA);
	endtask

	task automatic add_word();
		int unsigned n;
		logic [7:0]  qc;
		n  = $urandom_range(1, 6);
		qc = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
		case ($urandom_range(7))
			0: begin
				draft.push_back(qc);
				repeat (n) draft.push_back(text_char());
				if ($urandom_range(5) != 0)
					draft.push_back(qc);
			end
			1: begin
				draft.push_back(ident_char());
				draft.push_back(qc);
				repeat (n) draft.push_back(text_char());
				if ($urandom_range(5) != 0)
					draft.push_back(qc);
				draft.push_back(ident_char());
			end
			default: begin
				repeat (n) draft.push_back(ident_char());
			end
		endcase
		if ($urandom_range(3) == 0)
			draft.push_back(CH_COLON);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			draft.push_back(s[i]);
	endtask

	task automatic queue_draft();
		markup_byte_t b;
		foreach (draft[i]) begin
			b.ch  = draft[i];
			b.eom = (i == draft.size() - 1);
			markup_bytes.push_back(b);
		end
		draft.delete();
	endtask

	task automatic add_markup();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 16))
				draft.push_back(noise_char());
		end else begin
			add_gap();
			add_word();
			repeat ($urandom_range(3)) begin
				add_gap();
				draft.push_back(CH_PIPE);
				add_gap();
				if ($urandom_range(7) != 0)
					add_word();
				if ($urandom_range(2) == 0) begin
					add_gap();
					add_word();
					if ($urandom_range(1)) begin
						draft.push_back(CH_COMMA);
						add_gap();
						add_word();
					end
				end
			end
			if ($urandom_range(3) == 0)
				add_gap();
		end
		if (draft.size() == 0)
			draft.push_back(CH_SPACE);
	endtask

	task automatic wait_drained();
		while (markup_bytes.size() != 0 || s_tvalid || pending_tokens.size() != 0)
			@(negedge clk);
	endtask

	// ---- driver ----
	always @(negedge clk) begin : drive
		markup_byte_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || byte_taken) begin
				if (markup_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					nxt = markup_bytes.pop_front();
					s_tdata  <= nxt.ch;
					s_tlast  <= nxt.eom;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---- monitor ----
	always @(posedge clk) begin : observe
		token_t got;
		token_t want;
		if (arst_n) begin
			byte_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				tokenize_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got.kind   = kind_t'(m_tuser);
				got.start  = m_tdata[START_W-1:0];
				got.length = m_tdata[START_W+LEN_W-1:START_W];
				got.done   = m_tlast;
				if (pending_tokens.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected token: expected none, got kind %0d start %0d len %0d done %0d",
						$time, got.kind, got.start, got.length, got.done);
				end else begin
					want = pending_tokens.pop_front();
					if (got.kind !== want.kind || got.start !== want.start ||
							got.length !== want.length || got.done !== want.done) begin
						mismatch_count++;
						$display("%0t: token mismatch: expected kind %0d start %0d len %0d done %0d",
							$time, want.kind, want.start, want.length, want.done);
						$display("%0t:                 got      kind %0d start %0d len %0d done %0d",
							$time, got.kind, got.start, got.length, got.done);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---- sequence ----
	initial begin : sequencer
		int unsigned gap_by_phase[4];
		int unsigned stall_by_phase[4];
		int unsigned added;
		gap_by_phase   = '{0, 84, 0, 26};
		stall_by_phase = '{0, 0, 84, 26};

		repeat (8) @(posedge clk);
		#5 arst_n = 1'b1;

		// blank markup: end marker only
		add_text(" ");
		queue_draft();
		// single-byte name cut by the end
		add_text("a");
		queue_draft();
		// quoted name, filter with trailing colon cut by the end
		add_text("'x y'|f:");
		queue_draft();
		// inner quote hides the pipe; filter that is only a colon
		add_text("b\"c|d\"|:");
		queue_draft();
		// pipe with no filter name after it
		add_text("n|");
		queue_draft();
		// extreme byte values, comma closes the name
		draft.push_back(8'hFF);
		draft.push_back(CH_COMMA);
		draft.push_back(8'h00);
		queue_draft();
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct   = gap_by_phase[ph];
			recv_stall_pct = stall_by_phase[ph];
			if (ph == 0) begin
				// offsets past the saturation point
				repeat (MAX_LEN - 3) draft.push_back(CH_SPACE);
				add_text("name12345 | flt:");
				queue_draft();
				// fragment longer than the maximum length
				repeat (MAX_LEN + 104) draft.push_back(8'h78);
				queue_draft();
			end
			added = 0;
			while (added < PHASE_BYTES) begin
				add_markup();
				added += draft.size();
				queue_draft();
			end
			wait_drained();
		end

		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
